[hdl/sfec_pkg.sv]
// Shared types, constants and the CRC byte update for the status frame encoder.
// Used by sfec_ctrl, sfec_dp and the status_frame_encoder_crc16 top level.
`timescale 1ns / 1ps

package sfec_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN   = 22;
  localparam int unsigned IDX_W       = 5;
  localparam logic [IDX_W-1:0] IDX_FIRST = '0;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);

  localparam logic [7:0] SYNC_A      = 8'hE4;
  localparam logic [7:0] SYNC_B      = 8'hEB;
  localparam logic [15:0] PAYLOAD_LEN = 16'd14;

  // Input beat: five state bytes, then the 64-bit timestamp
  localparam int unsigned EVT_W = 104;

  // CRC-16, MSB first, no reflection, no final xor
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_VERSION = 2'd0,
    REG_CLASS   = 2'd1,
    REG_ID      = 2'd2
  } reg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic             capture;  // latch a new event beat
    logic             load;     // move frame byte idx into the output register
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register empty or being drained this cycle
  } dp_stat_t;

  // One byte through the CRC, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/sfec_ctrl.sv]
// Frame sequencer for the status frame encoder: input handshake and byte counter.
// Depends on sfec_pkg.
`timescale 1ns / 1ps

module sfec_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sfec_pkg::dp_stat_t stat,
  output sfec_pkg::dp_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t                     state_r, state_nxt;
  logic [sfec_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       load;
  logic                       accept;

  // A byte moves out whenever the output register has room
  assign load = (state_r == ST_SEND) && stat.slot_free;

  // Next event is taken while the last CRC byte is loaded
  assign in_tready = (state_r == ST_IDLE) || (load && (idx_r == sfec_pkg::IDX_LAST));
  assign accept    = in_tvalid && in_tready;

  assign cmd.capture = accept;
  assign cmd.load    = load;
  assign cmd.idx     = idx_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SEND;
          idx_nxt   = sfec_pkg::IDX_FIRST;
        end
      end
      ST_SEND: begin
        if (load) begin
          if (idx_r == sfec_pkg::IDX_LAST) begin
            idx_nxt   = sfec_pkg::IDX_FIRST;
            state_nxt = accept ? ST_SEND : ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = sfec_pkg::IDX_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= sfec_pkg::IDX_FIRST;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[hdl/sfec_dp.sv]
// Datapath of the status frame encoder: config registers, event latch,
// byte select, running CRC and the output register. Depends on sfec_pkg.
`timescale 1ns / 1ps

module sfec_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sfec_pkg::dp_cmd_t            cmd,
  output sfec_pkg::dp_stat_t           stat,
  input  logic [sfec_pkg::EVT_W-1:0]   in_tdata,
  input  logic                         cfg_valid,
  input  logic [1:0]                   cfg_index,
  input  logic [7:0]                   cfg_data,
  output logic [7:0]                   out_tdata,
  output logic                         out_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready
);

  logic [7:0]                 version_r, class_r, id_r;
  logic [sfec_pkg::EVT_W-1:0] evt_r;
  logic [15:0]                crc_r, crc_nxt;
  logic [7:0]                 byte_sel;
  logic [7:0]                 obyte_r;
  logic                       olast_r;
  logic                       ovalid_r, ovalid_nxt;
  logic [3:0]                 evt_byte;

  assign stat.slot_free = !ovalid_r || out_tready;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 8'd0;
      class_r   <= 8'd1;
      id_r      <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfec_pkg::REG_VERSION: version_r <= cfg_data;
        sfec_pkg::REG_CLASS:   class_r   <= cfg_data;
        sfec_pkg::REG_ID:      id_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Event latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      evt_r <= in_tdata;
    end
  end

  // Frame byte select; bytes 7..19 come straight from the event beat
  assign evt_byte = 4'(cmd.idx - 5'd7);

  always_comb begin
    case (cmd.idx)
      5'd0:    byte_sel = sfec_pkg::SYNC_A;
      5'd1:    byte_sel = sfec_pkg::SYNC_B;
      5'd2:    byte_sel = class_r;
      5'd3:    byte_sel = id_r;
      5'd4:    byte_sel = sfec_pkg::PAYLOAD_LEN[7:0];
      5'd5:    byte_sel = sfec_pkg::PAYLOAD_LEN[15:8];
      5'd6:    byte_sel = version_r;
      5'd20:   byte_sel = crc_r[15:8];
      5'd21:   byte_sel = crc_r[7:0];
      default: byte_sel = evt_r[evt_byte*8 +: 8];
    endcase
  end

  // Running CRC, restarted on the first byte of each frame
  always_comb begin
    crc_nxt = crc_r;
    if (cmd.load && (cmd.idx < 5'd20)) begin
      crc_nxt = sfec_pkg::crc_byte((cmd.idx == sfec_pkg::IDX_FIRST) ?
                                   sfec_pkg::CRC_INIT : crc_r, byte_sel);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  // Output register
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obyte_r <= byte_sel;
      olast_r <= (cmd.idx == sfec_pkg::IDX_LAST);
    end
  end

  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tvalid = ovalid_r;

endmodule

[hdl/status_frame_encoder_crc16.sv]
// Top level of the status frame encoder: one event beat in, 22 frame bytes out.
// Depends on sfec_pkg, sfec_ctrl and sfec_dp.
//
//   channel | direction | handshake            | payload
//   in_     | slave     | in_tvalid/in_tready  | in_tdata 104 bits (event)
//   out_    | master    | out_tvalid/out_tready| out_tdata frame byte, out_tlast
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index 2 bits, cfg_data 8 bits
//
// Each event goes out one frame byte at a time through the byte-wide output
// register; the next event is accepted on the cycle the last CRC byte is loaded.
// The CRC register advances one byte per cycle as bytes leave, unless out_tready stalls.
// Reset (rst_n low, synchronous) sets version 0, class 1, id 1 and empties the
// output. A stall on out_tready holds the output byte and the sequencer.
`timescale 1ns / 1ps

module status_frame_encoder_crc16 (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: system, radio, sensor, storage, switch states (8 each), time_ms (64)
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sfec_pkg::EVT_W-1:0] in_tdata,
  // out_tdata: frame_byte (8)
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data
);

  sfec_pkg::dp_cmd_t  cmd;
  sfec_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sfec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfec_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

[test/sfec_frame_checker.sv]
// Scoreboard for the status frame encoder: watches the event, frame and register channels,
// builds the expected 22-byte frame per accepted event and compares every output beat.
// Depends on sfec_pkg for widths, sync bytes, CRC constants and register indexes.
`timescale 1ns / 1ps

module sfec_frame_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [sfec_pkg::EVT_W-1:0] in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [7:0]                 out_tdata,
  input  logic                       out_tlast,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data,
  output int                         mismatches,
  output int                         bytes_due
);
  import sfec_pkg::*;

  localparam int unsigned CRC_SPAN    = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t frame_bytes_q[$];

  // local copy of the register file
  logic [7:0] version_r;
  logic [7:0] class_r;
  logic [7:0] id_r;
  int         err_cnt;

  // bit-serial CRC-16, MSB first
  function automatic logic [15:0] crc16_shift(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // expected frame for one event beat, queued in transmit order
  task automatic queue_frame(input logic [EVT_W-1:0] evt);
    logic [7:0]  f [FRAME_LEN];
    logic [15:0] crc;
    frame_byte_t fb;
    f[0] = SYNC_A;
    f[1] = SYNC_B;
    f[2] = class_r;
    f[3] = id_r;
    f[4] = PAYLOAD_LEN[7:0];
    f[5] = PAYLOAD_LEN[15:8];
    f[6] = version_r;
    for (int i = 0; i < 5; i++) begin
      f[7 + i] = evt[8 * i +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      f[12 + i] = evt[40 + 8 * i +: 8];
    end
    crc = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      crc = crc16_shift(crc, f[i]);
    end
    f[CRC_SPAN]     = crc[15:8];
    f[CRC_SPAN + 1] = crc[7:0];
    for (int i = 0; i < FRAME_LEN; i++) begin
      fb.data = f[i];
      fb.last = (i == FRAME_LEN - 1);
      frame_bytes_q.push_back(fb);
    end
  endtask

  // tally and report a failure
  task automatic flag_error(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch: expected %02h, actual %02h", $time, what, want, got);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      version_r = 8'h00;
      class_r   = 8'h01;
      id_r      = 8'h01;
      err_cnt   = 0;
      frame_bytes_q.delete();
    end else begin
      // register writes; index out of range is dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VERSION: version_r = cfg_data;
          REG_CLASS:   class_r   = cfg_data;
          REG_ID:      id_r      = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        queue_frame(in_tdata);
      end
      // compare each output beat with the oldest expected byte
      if (out_tvalid && out_tready) begin
        if (frame_bytes_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual %02h last %0b",
                   $time, out_tdata, out_tlast);
          err_cnt++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_tdata !== want.data) begin
            flag_error("frame_byte", want.data, out_tdata);
          end
          if (out_tlast !== want.last) begin
            flag_error("last_byte", {7'd0, want.last}, {7'd0, out_tlast});
          end
        end
      end
    end
    mismatches <= err_cnt;
    bytes_due  <= frame_bytes_q.size();
  end

endmodule

[test/tb.sv]
// Testbench top for status_frame_encoder_crc16: clock, reset, event and register stimulus,
// a stalling frame receiver, a watchdog and the verdict.
// Depends on sfec_pkg, the encoder RTL and sfec_frame_checker.
`timescale 1ns / 1ps

module tb;
  import sfec_pkg::*;

  localparam int          RESET_CYCLES   = 12;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          RAND_PHASES    = 8;
  localparam int          PHASE_EVENTS   = 16;
  localparam int          HOLD_PHASE     = 2;
  localparam logic [1:0]  REG_NONE       = 2'd3;  // no register behind this index

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [EVT_W-1:0] in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;
  logic             out_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [7:0]       cfg_data;

  int mismatches;
  int bytes_due;
  int quiet_cycles;
  bit hold_req = 1'b0;

  status_frame_encoder_crc16 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sfec_frame_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .bytes_due  (bytes_due)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // event beat layout: system in the low byte up to time_ms on top
  function automatic logic [EVT_W-1:0] pack_event(input logic [7:0] sys, input logic [7:0] radio,
                                                  input logic [7:0] sensor,
                                                  input logic [7:0] storage,
                                                  input logic [7:0] sw, input logic [63:0] t);
    return {t, sw, storage, sensor, radio, sys};
  endfunction

  // mostly random, with the byte extremes mixed in
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one event and hold it until taken; valid stays high on return
  task automatic send_event(input logic [EVT_W-1:0] evt);
    in_tdata  <= evt;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // one register write, channel idle afterwards
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait for every queued frame byte
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: stall pattern changes after a random span, plus one long hold-off
  initial begin
    rx_mode_t mode;
    int       span;
    int       hold_left;
    int       tick;
    mode       = RX_OPEN;
    span       = 0;
    hold_left  = 0;
    tick       = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(20, 120);
        end
        span--;
        case (mode)
          RX_OPEN:     out_tready <= 1'b1;
          RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_tready <= ((tick % 5) < 3);
          default:     out_tready <= 1'b1;
        endcase
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int sent;
    int burst;
    int gap;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_VERSION;
    cfg_data  <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, field extremes
    send_event(pack_event(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0));
    send_event(pack_event(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_event(pack_event(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 64'h0123_4567_89AB_CDEF));
    send_event(pack_event(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 64'h8000_0000_0000_0001));
    drain();

    // register extremes
    write_reg(REG_VERSION, 8'hFF);
    write_reg(REG_CLASS, 8'h00);
    write_reg(REG_ID, 8'hFF);
    send_event(pack_event(8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00, 64'h0000_0000_FFFF_FFFF));
    send_event(pack_event(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 64'hFFFF_FFFF_0000_0000));
    send_event(pack_event(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'h0));
    drain();

    write_reg(REG_VERSION, 8'h00);
    write_reg(REG_CLASS, 8'hFF);
    write_reg(REG_ID, 8'h00);
    send_event(pack_event(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 64'hDEAD_BEEF_CAFE_F00D));
    send_event(pack_event(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 64'h5555_5555_AAAA_AAAA));
    drain();

    // write to an index with no register behind it: must change nothing
    write_reg(REG_NONE, 8'hA5);
    send_event(pack_event(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 64'hAAAA_AAAA_5555_5555));
    send_event(pack_event(8'h3C, 8'hC3, 8'h0F, 8'hF0, 8'h99, 64'h0000_0000_0000_00FF));
    drain();

    // random phases: new register settings between them, bursty sender
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 3) != 0) begin
          write_reg(2'(r), pick_byte());
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_NONE, 8'($urandom));
      end
      // long receiver hold-off while the sender keeps offering
      if (ph == HOLD_PHASE) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_EVENTS) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && sent < PHASE_EVENTS; b++) begin
          if ($urandom_range(0, 3) == 0) begin
            send_event(pack_event(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                                  pick_byte(), {pick_byte(), pick_byte(), pick_byte(),
                                  pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                                  pick_byte()}));
          end else begin
            send_event(pack_event(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                  8'($urandom), {$urandom, $urandom}));
          end
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0 || ph == HOLD_PHASE) ? 0 : $urandom_range(1, 30);
        if (gap > 0 && sent < PHASE_EVENTS) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && bytes_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
